>>> rtl/adp_pkg.sv
`default_nettype none

package adp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_MAGIC     = 4'd1,
        PH_NAME_LEN  = 4'd2,
        PH_NAME      = 4'd3,
        PH_DNAME_LEN = 4'd4,
        PH_DNAME     = 4'd5,
        PH_DATA_LEN  = 4'd6,
        PH_DATA      = 4'd7,
        PH_XCOUNT    = 4'd8,
        PH_XNAME_LEN = 4'd9,
        PH_XNAME     = 4'd10,
        PH_XDATA_LEN = 4'd11,
        PH_XDATA     = 4'd12,
        PH_DONE      = 4'd13,
        PH_BAD       = 4'd14
    } phase_t;

    typedef enum logic [3:0] {
        KIND_NONE       = 4'd0,
        KIND_MAGIC      = 4'd1,
        KIND_NAME_LEN   = 4'd2,
        KIND_NAME_CHAR  = 4'd3,
        KIND_DNAME_LEN  = 4'd4,
        KIND_DNAME_CHAR = 4'd5,
        KIND_DATA_LEN   = 4'd6,
        KIND_DATA_BYTE  = 4'd7,
        KIND_XCOUNT     = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ST_PARSING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_BAD      = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;

    localparam logic [7:0] MAGIC [4] = '{8'h53, 8'h41, 8'h4F, 8'h31};
    localparam logic [1:0] MAGIC_LAST = 2'd3;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] field_index;
        logic [7:0] field_remaining;
        logic [3:0] extra_slot;
        logic [3:0] extras_total;
        logic       magic_bad;
    } parse_state_t;

    typedef struct packed {
        kind_t      field_kind;
        logic [3:0] driver_slot;
        logic [7:0] position;
        logic [7:0] field_value;
        status_t    status;
    } parse_result_t;

    function automatic logic [7:0] clamp_len(input logic [7:0] v, input logic [7:0] lim);
        return (v > lim) ? lim : v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/adp_in_if.sv
`default_nettype none

interface adp_in_if;
    logic       valid;
    logic       ready;
    logic       begin_req;
    logic [7:0] data_byte;

    modport source (output valid, output begin_req, output data_byte, input ready);
    modport sink (input valid, input begin_req, input data_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/adp_out_if.sv
`default_nettype none

interface adp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] field_kind;
    logic [3:0] driver_slot;
    logic [7:0] position;
    logic [7:0] field_value;
    logic [1:0] status;

    modport source (
        output valid, output field_kind, output driver_slot, output position,
        output field_value, output status, input ready
    );
    modport sink (
        input valid, input field_kind, input driver_slot, input position,
        input field_value, input status, output ready
    );
endinterface

`default_nettype wire

>>> rtl/addon_descriptor_parser.sv
`default_nettype none

// add-on memory descriptor parser
// rx carries one descriptor byte per request: begin_req marks the first magic
// byte of a new descriptor and restarts the parse, data_byte is the byte read
// tx carries one tagged result per request: field_kind, driver_slot, position,
// field_value (lengths and counts after clamping) and status
// a request taken from rx is parsed from the input register into the result register,
// which drives tx (two register stages: input register, result register)
// throughput: one byte per cycle unless tx stalls, set by the combinational
// parse step between the input and result registers, which also updates the state
// when tx stalls the result register holds its request and the input register
// fills; rx ready drops once both are occupied and rises the cycle tx takes
// the waiting result
// reset clears both stages and puts the parser in idle: bytes before the
// first begin_req are reported as ignored
// NAME_MAX, DRIVER_NAME_MAX, DRIVER_DATA_MAX and EXTRA_DRIVERS_MAX set the
// clamps for the name, driver name and data lengths and the extra count

module addon_descriptor_parser #(
    parameter int NAME_MAX          = 32,
    parameter int DRIVER_NAME_MAX   = 32,
    parameter int DRIVER_DATA_MAX   = 32,
    parameter int EXTRA_DRIVERS_MAX = 8
) (
    input wire logic clk,
    input wire logic rst_n,
    adp_in_if.sink   rx,
    adp_out_if.source tx
);

    localparam logic [7:0] NAME_LIM  = 8'(NAME_MAX);
    localparam logic [7:0] DNAME_LIM = 8'(DRIVER_NAME_MAX);
    localparam logic [7:0] DATA_LIM  = 8'(DRIVER_DATA_MAX);
    localparam logic [7:0] XDRV_LIM  = 8'(EXTRA_DRIVERS_MAX);

    // input stage
    logic       in_valid_reg;
    logic       in_begin_reg;
    logic [7:0] in_byte_reg;

    // result stage
    logic                   out_valid_reg;
    adp_pkg::parse_result_t out_res_reg;

    // parser state
    adp_pkg::parse_state_t  state_reg;
    adp_pkg::parse_state_t  state_next;
    adp_pkg::parse_result_t res_next;

    logic advance;
    logic rx_take;

    // the input byte moves into the result register when that is free or drained
    assign advance  = in_valid_reg && (!out_valid_reg || tx.ready);
    assign rx.ready = !in_valid_reg || advance;
    assign rx_take  = rx.valid && rx.ready;

    adp_parse #(
        .NAME_LIM  (NAME_LIM),
        .DNAME_LIM (DNAME_LIM),
        .DATA_LIM  (DATA_LIM),
        .XDRV_LIM  (XDRV_LIM)
    ) u_parse (
        .begin_req (in_begin_reg),
        .data_byte (in_byte_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_begin_reg <= rx.begin_req;
            in_byte_reg  <= rx.data_byte;
        end
    end

    // state changes only when a byte is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase           <= adp_pkg::PH_IDLE;
            state_reg.field_index     <= 8'd0;
            state_reg.field_remaining <= 8'd0;
            state_reg.extra_slot      <= 4'd0;
            state_reg.extras_total    <= 4'd0;
            state_reg.magic_bad       <= 1'b0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (tx.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res_next;
    end

    assign tx.valid       = out_valid_reg;
    assign tx.field_kind  = out_res_reg.field_kind;
    assign tx.driver_slot = out_res_reg.driver_slot;
    assign tx.position    = out_res_reg.position;
    assign tx.field_value = out_res_reg.field_value;
    assign tx.status      = out_res_reg.status;

endmodule

`default_nettype wire

>>> rtl/adp_parse.sv
`default_nettype none

module adp_parse #(
    parameter logic [7:0] NAME_LIM  = 8'd32,
    parameter logic [7:0] DNAME_LIM = 8'd32,
    parameter logic [7:0] DATA_LIM  = 8'd32,
    parameter logic [7:0] XDRV_LIM  = 8'd8
) (
    input  wire logic                  begin_req,
    input  wire logic [7:0]            data_byte,
    input  wire adp_pkg::parse_state_t cur,
    output adp_pkg::parse_state_t      nxt,
    output adp_pkg::parse_result_t     res
);

    adp_pkg::parse_state_t st;
    logic                  extra;
    logic                  drv_done;
    logic [7:0]            c;

    always_comb
    begin
        st       = cur;
        extra    = (cur.phase >= adp_pkg::PH_XNAME_LEN) && (cur.phase <= adp_pkg::PH_XDATA);
        drv_done = 1'b0;
        c        = 8'd0;

        res.field_kind  = adp_pkg::KIND_NONE;
        res.driver_slot = 4'd0;
        res.position    = 8'd0;
        res.field_value = 8'd0;
        res.status      = adp_pkg::ST_PARSING;

        // a new descriptor restarts from magic byte zero
        if (begin_req)
        begin
            st.phase           = adp_pkg::PH_MAGIC;
            st.field_index     = 8'd0;
            st.field_remaining = 8'd0;
            st.extra_slot      = 4'd0;
            st.extras_total    = 4'd0;
            st.magic_bad       = 1'b0;
            extra              = 1'b0;
        end

        if (extra)
            res.driver_slot = st.extra_slot + 4'd1;

        case (st.phase)
            adp_pkg::PH_MAGIC:
            begin
                res.field_kind  = adp_pkg::KIND_MAGIC;
                res.position    = st.field_index;
                res.field_value = data_byte;
                if (data_byte != adp_pkg::MAGIC[st.field_index[1:0]])
                    st.magic_bad = 1'b1;
                if (st.field_index >= {6'd0, adp_pkg::MAGIC_LAST})
                begin
                    st.field_index = 8'd0;
                    if (st.magic_bad)
                    begin
                        res.status = adp_pkg::ST_BAD;
                        st.phase   = adp_pkg::PH_BAD;
                    end
                    else
                        st.phase = adp_pkg::PH_NAME_LEN;
                end
                else
                    st.field_index = st.field_index + 8'd1;
            end
            adp_pkg::PH_NAME_LEN:
            begin
                res.field_kind     = adp_pkg::KIND_NAME_LEN;
                c                  = adp_pkg::clamp_len(data_byte, NAME_LIM);
                res.field_value    = c;
                st.field_index     = 8'd0;
                st.field_remaining = c;
                st.phase           = (c != 8'd0) ? adp_pkg::PH_NAME : adp_pkg::PH_DNAME_LEN;
            end
            adp_pkg::PH_NAME:
            begin
                res.field_kind     = adp_pkg::KIND_NAME_CHAR;
                res.position       = st.field_index;
                res.field_value    = data_byte;
                st.field_index     = st.field_index + 8'd1;
                st.field_remaining = st.field_remaining - 8'd1;
                if (st.field_remaining == 8'd0)
                    st.phase = adp_pkg::PH_DNAME_LEN;
            end
            adp_pkg::PH_DNAME_LEN, adp_pkg::PH_XNAME_LEN:
            begin
                res.field_kind     = adp_pkg::KIND_DNAME_LEN;
                c                  = adp_pkg::clamp_len(data_byte, DNAME_LIM);
                res.field_value    = c;
                st.field_index     = 8'd0;
                st.field_remaining = c;
                if (c != 8'd0)
                    st.phase = extra ? adp_pkg::PH_XNAME : adp_pkg::PH_DNAME;
                else
                    st.phase = extra ? adp_pkg::PH_XDATA_LEN : adp_pkg::PH_DATA_LEN;
            end
            adp_pkg::PH_DNAME, adp_pkg::PH_XNAME:
            begin
                res.field_kind     = adp_pkg::KIND_DNAME_CHAR;
                res.position       = st.field_index;
                res.field_value    = data_byte;
                st.field_index     = st.field_index + 8'd1;
                st.field_remaining = st.field_remaining - 8'd1;
                if (st.field_remaining == 8'd0)
                    st.phase = extra ? adp_pkg::PH_XDATA_LEN : adp_pkg::PH_DATA_LEN;
            end
            adp_pkg::PH_DATA_LEN, adp_pkg::PH_XDATA_LEN:
            begin
                res.field_kind     = adp_pkg::KIND_DATA_LEN;
                c                  = adp_pkg::clamp_len(data_byte, DATA_LIM);
                res.field_value    = c;
                st.field_index     = 8'd0;
                st.field_remaining = c;
                if (c != 8'd0)
                    st.phase = extra ? adp_pkg::PH_XDATA : adp_pkg::PH_DATA;
                else
                    drv_done = 1'b1;
            end
            adp_pkg::PH_DATA, adp_pkg::PH_XDATA:
            begin
                res.field_kind     = adp_pkg::KIND_DATA_BYTE;
                res.position       = st.field_index;
                res.field_value    = data_byte;
                st.field_index     = st.field_index + 8'd1;
                st.field_remaining = st.field_remaining - 8'd1;
                if (st.field_remaining == 8'd0)
                    drv_done = 1'b1;
            end
            adp_pkg::PH_XCOUNT:
            begin
                res.field_kind  = adp_pkg::KIND_XCOUNT;
                c               = adp_pkg::clamp_len(data_byte, XDRV_LIM);
                res.field_value = {4'd0, c[3:0]};
                st.extras_total = c[3:0];
                st.extra_slot   = 4'd0;
                if (c[3:0] == 4'd0)
                begin
                    st.phase   = adp_pkg::PH_DONE;
                    res.status = adp_pkg::ST_COMPLETE;
                end
                else
                    st.phase = adp_pkg::PH_XNAME_LEN;
            end
            default:
            begin
                res.driver_slot = 4'd0;
                res.status      = adp_pkg::ST_IGNORED;
            end
        endcase

        // end of one driver's fields: go to the extra count, the next extra driver or done
        if (drv_done)
        begin
            if (!extra)
                st.phase = adp_pkg::PH_XCOUNT;
            else
            begin
                st.extra_slot = st.extra_slot + 4'd1;
                if (st.extra_slot >= st.extras_total)
                begin
                    st.phase   = adp_pkg::PH_DONE;
                    res.status = adp_pkg::ST_COMPLETE;
                end
                else
                    st.phase = adp_pkg::PH_XNAME_LEN;
            end
        end

        nxt = st;
    end

endmodule

`default_nettype wire

>>> rtl/adp_checker.sv
`default_nettype none

module adp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       tx_valid,
    input wire logic       tx_ready,
    input wire logic [3:0] field_kind,
    input wire logic [3:0] driver_slot,
    input wire logic [7:0] position,
    input wire logic [7:0] field_value,
    input wire logic [1:0] status
);

    localparam logic [3:0] KIND_NONE  = adp_pkg::KIND_NONE;
    localparam logic [3:0] KIND_MAGIC = adp_pkg::KIND_MAGIC;
    localparam logic [1:0] ST_BAD     = adp_pkg::ST_BAD;
    localparam logic [1:0] ST_IGNORED = adp_pkg::ST_IGNORED;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> $stable(field_kind) && $stable(driver_slot)
            && $stable(position) && $stable(field_value) && $stable(status))
        else $error("stalled result changed");

    // bad magic is only flagged on the fourth magic byte
    a_bad_on_magic: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && status == ST_BAD |-> field_kind == KIND_MAGIC && position == 8'd3)
        else $error("bad magic outside fourth magic byte");

    // ignored bytes and untagged results go together, with all fields zero
    a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (status == ST_IGNORED || field_kind == KIND_NONE) |->
            status == ST_IGNORED && field_kind == KIND_NONE && driver_slot == 4'd0
            && position == 8'd0 && field_value == 8'd0)
        else $error("ignored byte carries field data");

endmodule

bind addon_descriptor_parser adp_checker u_adp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tx_valid    (tx.valid),
    .tx_ready    (tx.ready),
    .field_kind  (tx.field_kind),
    .driver_slot (tx.driver_slot),
    .position    (tx.position),
    .field_value (tx.field_value),
    .status      (tx.status)
);

`default_nettype wire
